>>> rtl/dllc_pkg.sv
`timescale 1ns / 1ps

package dllc_pkg;

    localparam int POOL_ENTRIES_DEF = 64;
    localparam int DATA_BITS_DEF    = 32;

    localparam logic [3:0] K_QUERY      = 4'd0;
    localparam logic [3:0] K_INS_FIRST  = 4'd1;
    localparam logic [3:0] K_INS_LAST   = 4'd2;
    localparam logic [3:0] K_INS_BEFORE = 4'd3;
    localparam logic [3:0] K_INS_AFTER  = 4'd4;
    localparam logic [3:0] K_DEL_FIRST  = 4'd5;
    localparam logic [3:0] K_DEL_LAST   = 4'd6;
    localparam logic [3:0] K_DEL_BEFORE = 4'd7;
    localparam logic [3:0] K_DEL_AFTER  = 4'd8;
    localparam logic [3:0] K_SET        = 4'd9;
    localparam logic [3:0] K_FIRST      = 4'd10;
    localparam logic [3:0] K_LAST       = 4'd11;
    localparam logic [3:0] K_NEXT       = 4'd12;
    localparam logic [3:0] K_PREV       = 4'd13;
    localparam logic [3:0] K_DISPOSE    = 4'd14;

    typedef struct packed {
        logic [3:0]          kind;
        logic signed [31:0]  value;
    } dllc_req_t;

    typedef struct packed {
        logic                pool_full_error;
        logic [6:0]          list_length;
        logic                cursor_valid;
        logic signed [31:0]  cursor_value;
        logic                list_nonempty;
        logic signed [31:0]  head_value;
        logic signed [31:0]  tail_value;
    } dllc_rsp_t;

endpackage

>>> rtl/dllc_req_if.sv
`timescale 1ns / 1ps

interface dllc_req_if
    import dllc_pkg::*;
();
    logic      valid;
    logic      ready;
    dllc_req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/dllc_rsp_if.sv
`timescale 1ns / 1ps

interface dllc_rsp_if
    import dllc_pkg::*;
();
    logic      valid;
    logic      ready;
    dllc_rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/dllc_ram.sv
`timescale 1ns / 1ps

module dllc_ram
    import dllc_pkg::*;
#(
    parameter int DEPTH = POOL_ENTRIES_DEF,
    parameter int WIDTH = DATA_BITS_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/dllc_ram2r.sv
`timescale 1ns / 1ps

module dllc_ram2r
    import dllc_pkg::*;
#(
    parameter int DEPTH = POOL_ENTRIES_DEF,
    parameter int WIDTH = DATA_BITS_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

>>> rtl/doubly_linked_list_cursor_engine_unit.sv
// Flow: an accepted request passes LOOK, COMMIT1 and COMMIT2 (CHAIN after LOOK for delete
//   before or after the cursor, the second link lookup); COMMIT2 waits until rsp is free.
// Requests are taken one at a time, only in IDLE, since the node stores have registered
//   reads and each link store takes two writes per operation.
// Reset (rst_n low, asynchronous): empty list, cursor inactive, whole pool free at once;
//   the node stores are not cleared and no clearing pass runs.
`timescale 1ns / 1ps

module doubly_linked_list_cursor_engine_unit
    import dllc_pkg::*;
#(
    parameter int POOL_ENTRIES = POOL_ENTRIES_DEF,
    parameter int DATA_BITS    = DATA_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    dllc_req_if.sink   req,
    dllc_rsp_if.source rsp
);

    localparam int IW = $clog2(POOL_ENTRIES + 1);
    localparam int AW = $clog2(POOL_ENTRIES);
    localparam logic [IW-1:0] NIL = IW'(POOL_ENTRIES);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_LOOK    = 3'd1;
    localparam logic [2:0] ST_CHAIN   = 3'd2;
    localparam logic [2:0] ST_COMMIT1 = 3'd3;
    localparam logic [2:0] ST_COMMIT2 = 3'd4;

    localparam logic [1:0] LD_NONE = 2'd0;
    localparam logic [1:0] LD_HEAD = 2'd1;
    localparam logic [1:0] LD_TAIL = 2'd2;
    localparam logic [1:0] LD_CUR  = 2'd3;

    typedef struct packed {
        logic          en;
        logic [AW-1:0] addr;
        logic [IW-1:0] data;
    } link_wr_t;

    typedef struct packed {
        logic                 en;
        logic [AW-1:0]        addr;
        logic [DATA_BITS-1:0] data;
    } data_wr_t;

    function automatic logic live(input logic [IW-1:0] i);
        return i < NIL;
    endfunction

    function automatic link_wr_t link_wr(input logic [IW-1:0] a, input logic [IW-1:0] d);
        link_wr_t w;
        w.en   = 1'b1;
        w.addr = a[AW-1:0];
        w.data = d;
        return w;
    endfunction

    function automatic logic signed [31:0] out_val(input logic [IW-1:0] i,
                                                   input logic signed [DATA_BITS-1:0] d);
        if (live(i))
        begin
            return 32'(d);
        end
        return '0;
    endfunction

    logic [2:0]  state_reg, state_next;
    logic [3:0]  kind_reg;
    logic signed [DATA_BITS-1:0] value_reg;

    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic [IW-1:0] fhead_reg, fhead_next;
    logic [IW-1:0] fresh_reg, fresh_next;
    logic [IW-1:0] count_reg, count_next;
    logic [IW-1:0] node_reg, node_next;

    logic signed [DATA_BITS-1:0] hval_reg, hval_next;
    logic signed [DATA_BITS-1:0] tval_reg, tval_next;
    logic signed [DATA_BITS-1:0] cval_reg, cval_next;

    link_wr_t nx1_reg, nx1_next, nx2_reg, nx2_next;
    link_wr_t pv1_reg, pv1_next, pv2_reg, pv2_next;
    data_wr_t dt_reg, dt_next;
    logic [1:0] ld_reg, ld_next;
    logic       full_reg, full_next;

    logic      rsp_valid_reg;
    dllc_rsp_t rsp_data_reg, rsp_data_next;
    logic      rsp_free;
    logic      accept;

    logic [IW-1:0] alloc_idx;
    logic          avail;
    logic          take;

    logic [AW-1:0] na_raddr, nb_raddr, pv_raddr, dt_raddr;
    logic [IW-1:0] na_rdata, nb_rdata, pv_rdata;
    logic [DATA_BITS-1:0] dt_rdata;
    link_wr_t nx_wr, pv_wr;
    data_wr_t dt_wr;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign rsp_free  = !rsp_valid_reg || rsp.ready;

    assign na_raddr = (state_reg != ST_IDLE) ? na_rdata[AW-1:0] :
                      (req.payload.kind == K_DEL_FIRST) ? head_reg[AW-1:0] : cur_reg[AW-1:0];
    assign pv_raddr = (state_reg != ST_IDLE) ? pv_rdata[AW-1:0] :
                      (req.payload.kind == K_DEL_LAST) ? tail_reg[AW-1:0] : cur_reg[AW-1:0];
    assign nb_raddr = fhead_reg[AW-1:0];
    assign dt_raddr = (kind_reg == K_DEL_FIRST || kind_reg == K_NEXT) ?
                      na_rdata[AW-1:0] : pv_rdata[AW-1:0];

    assign nx_wr = (state_reg == ST_COMMIT1) ? nx1_reg :
                   (state_reg == ST_COMMIT2) ? nx2_reg : '0;
    assign pv_wr = (state_reg == ST_COMMIT1) ? pv1_reg :
                   (state_reg == ST_COMMIT2) ? pv2_reg : '0;
    assign dt_wr = (state_reg == ST_COMMIT1) ? dt_reg : '0;

    dllc_ram2r #(.DEPTH(POOL_ENTRIES), .WIDTH(IW)) u_next_mem (
        .clk     (clk),
        .we      (nx_wr.en),
        .waddr   (nx_wr.addr),
        .wdata   (nx_wr.data),
        .raddr_a (na_raddr),
        .raddr_b (nb_raddr),
        .rdata_a (na_rdata),
        .rdata_b (nb_rdata)
    );

    dllc_ram #(.DEPTH(POOL_ENTRIES), .WIDTH(IW)) u_prev_mem (
        .clk   (clk),
        .we    (pv_wr.en),
        .waddr (pv_wr.addr),
        .wdata (pv_wr.data),
        .raddr (pv_raddr),
        .rdata (pv_rdata)
    );

    dllc_ram #(.DEPTH(POOL_ENTRIES), .WIDTH(DATA_BITS)) u_data_mem (
        .clk   (clk),
        .we    (dt_wr.en),
        .waddr (dt_wr.addr),
        .wdata (dt_wr.data),
        .raddr (dt_raddr),
        .rdata (dt_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        cur_next   = cur_reg;
        fhead_next = fhead_reg;
        fresh_next = fresh_reg;
        count_next = count_reg;
        node_next  = node_reg;
        hval_next  = hval_reg;
        tval_next  = tval_reg;
        cval_next  = cval_reg;
        nx1_next   = nx1_reg;
        nx2_next   = nx2_reg;
        pv1_next   = pv1_reg;
        pv2_next   = pv2_reg;
        dt_next    = dt_reg;
        ld_next    = ld_reg;
        full_next  = full_reg;
        take       = 1'b0;
        avail      = live(fhead_reg) || (fresh_reg != NIL);
        alloc_idx  = live(fhead_reg) ? fhead_reg : fresh_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next  = ST_COMMIT1;
                nx1_next.en = 1'b0;
                nx2_next.en = 1'b0;
                pv1_next.en = 1'b0;
                pv2_next.en = 1'b0;
                dt_next.en  = 1'b0;
                ld_next     = LD_NONE;
                full_next   = 1'b0;
                unique case (kind_reg)
                    K_QUERY:
                    begin
                    end
                    K_INS_FIRST:
                    begin
                        if (!avail)
                        begin
                            full_next = 1'b1;
                        end
                        else
                        begin
                            take     = 1'b1;
                            pv1_next = link_wr(alloc_idx, NIL);
                            nx1_next = link_wr(alloc_idx, head_reg);
                            if (live(head_reg))
                            begin
                                pv2_next = link_wr(head_reg, alloc_idx);
                            end
                            else
                            begin
                                tail_next = alloc_idx;
                                tval_next = value_reg;
                            end
                            head_next = alloc_idx;
                            hval_next = value_reg;
                        end
                    end
                    K_INS_LAST:
                    begin
                        if (!avail)
                        begin
                            full_next = 1'b1;
                        end
                        else
                        begin
                            take     = 1'b1;
                            nx1_next = link_wr(alloc_idx, NIL);
                            pv1_next = link_wr(alloc_idx, tail_reg);
                            if (live(tail_reg))
                            begin
                                nx2_next = link_wr(tail_reg, alloc_idx);
                            end
                            else
                            begin
                                head_next = alloc_idx;
                                hval_next = value_reg;
                            end
                            tail_next = alloc_idx;
                            tval_next = value_reg;
                        end
                    end
                    K_INS_BEFORE:
                    begin
                        if (live(cur_reg))
                        begin
                            if (!avail)
                            begin
                                full_next = 1'b1;
                            end
                            else
                            begin
                                take     = 1'b1;
                                pv1_next = link_wr(alloc_idx, pv_rdata);
                                nx1_next = link_wr(alloc_idx, cur_reg);
                                if (live(pv_rdata))
                                begin
                                    nx2_next = link_wr(pv_rdata, alloc_idx);
                                end
                                else
                                begin
                                    head_next = alloc_idx;
                                    hval_next = value_reg;
                                end
                                pv2_next = link_wr(cur_reg, alloc_idx);
                            end
                        end
                    end
                    K_INS_AFTER:
                    begin
                        if (live(cur_reg))
                        begin
                            if (!avail)
                            begin
                                full_next = 1'b1;
                            end
                            else
                            begin
                                take     = 1'b1;
                                nx1_next = link_wr(alloc_idx, na_rdata);
                                pv1_next = link_wr(alloc_idx, cur_reg);
                                if (live(na_rdata))
                                begin
                                    pv2_next = link_wr(na_rdata, alloc_idx);
                                end
                                else
                                begin
                                    tail_next = alloc_idx;
                                    tval_next = value_reg;
                                end
                                nx2_next = link_wr(cur_reg, alloc_idx);
                            end
                        end
                    end
                    K_DEL_FIRST:
                    begin
                        if (live(head_reg))
                        begin
                            head_next = na_rdata;
                            if (live(na_rdata))
                            begin
                                pv1_next = link_wr(na_rdata, NIL);
                                ld_next  = LD_HEAD;
                            end
                            else
                            begin
                                tail_next = NIL;
                            end
                            if (cur_reg == head_reg)
                            begin
                                cur_next = NIL;
                            end
                            nx1_next   = link_wr(head_reg, fhead_reg);
                            fhead_next = head_reg;
                            count_next = count_reg - IW'(1);
                        end
                    end
                    K_DEL_LAST:
                    begin
                        if (live(tail_reg))
                        begin
                            tail_next = pv_rdata;
                            if (live(pv_rdata))
                            begin
                                nx1_next = link_wr(pv_rdata, NIL);
                                ld_next  = LD_TAIL;
                            end
                            else
                            begin
                                head_next = NIL;
                            end
                            if (cur_reg == tail_reg)
                            begin
                                cur_next = NIL;
                            end
                            nx2_next   = link_wr(tail_reg, fhead_reg);
                            fhead_next = tail_reg;
                            count_next = count_reg - IW'(1);
                        end
                    end
                    K_DEL_BEFORE:
                    begin
                        if (live(cur_reg) && live(pv_rdata))
                        begin
                            node_next  = pv_rdata;
                            state_next = ST_CHAIN;
                        end
                    end
                    K_DEL_AFTER:
                    begin
                        if (live(cur_reg) && live(na_rdata))
                        begin
                            node_next  = na_rdata;
                            state_next = ST_CHAIN;
                        end
                    end
                    K_SET:
                    begin
                        if (live(cur_reg))
                        begin
                            dt_next.en   = 1'b1;
                            dt_next.addr = cur_reg[AW-1:0];
                            dt_next.data = value_reg;
                            cval_next    = value_reg;
                            if (cur_reg == head_reg)
                            begin
                                hval_next = value_reg;
                            end
                            if (cur_reg == tail_reg)
                            begin
                                tval_next = value_reg;
                            end
                        end
                    end
                    K_FIRST:
                    begin
                        cur_next  = live(head_reg) ? head_reg : NIL;
                        cval_next = hval_reg;
                    end
                    K_LAST:
                    begin
                        cur_next  = live(tail_reg) ? tail_reg : NIL;
                        cval_next = tval_reg;
                    end
                    K_NEXT:
                    begin
                        if (live(cur_reg))
                        begin
                            cur_next = live(na_rdata) ? na_rdata : NIL;
                            ld_next  = LD_CUR;
                        end
                    end
                    K_PREV:
                    begin
                        if (live(cur_reg))
                        begin
                            cur_next = live(pv_rdata) ? pv_rdata : NIL;
                            ld_next  = LD_CUR;
                        end
                    end
                    K_DISPOSE:
                    begin
                        if (live(head_reg) && live(tail_reg))
                        begin
                            nx1_next   = link_wr(tail_reg, fhead_reg);
                            fhead_next = head_reg;
                        end
                        head_next  = NIL;
                        tail_next  = NIL;
                        cur_next   = NIL;
                        count_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
                if (take)
                begin
                    dt_next.en   = 1'b1;
                    dt_next.addr = alloc_idx[AW-1:0];
                    dt_next.data = value_reg;
                    if (live(fhead_reg))
                    begin
                        fhead_next = nb_rdata;
                    end
                    else
                    begin
                        fresh_next = fresh_reg + IW'(1);
                    end
                    count_next = count_reg + IW'(1);
                end
            end
            ST_CHAIN:
            begin
                state_next = ST_COMMIT1;
                if (kind_reg == K_DEL_BEFORE)
                begin
                    pv1_next = link_wr(cur_reg, pv_rdata);
                    if (live(pv_rdata))
                    begin
                        nx1_next = link_wr(pv_rdata, cur_reg);
                    end
                    else
                    begin
                        head_next = cur_reg;
                        hval_next = cval_reg;
                    end
                end
                else
                begin
                    nx1_next = link_wr(cur_reg, na_rdata);
                    if (live(na_rdata))
                    begin
                        pv1_next = link_wr(na_rdata, cur_reg);
                    end
                    else
                    begin
                        tail_next = cur_reg;
                        tval_next = cval_reg;
                    end
                end
                nx2_next   = link_wr(node_reg, fhead_reg);
                fhead_next = node_reg;
                count_next = count_reg - IW'(1);
            end
            ST_COMMIT1:
            begin
                state_next = ST_COMMIT2;
                case (ld_reg)
                    LD_HEAD: hval_next = dt_rdata;
                    LD_TAIL: tval_next = dt_rdata;
                    LD_CUR:  cval_next = dt_rdata;
                    default:
                    begin
                    end
                endcase
            end
            ST_COMMIT2:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_data_next.pool_full_error = full_reg;
        rsp_data_next.list_length     = 7'(count_reg);
        rsp_data_next.cursor_valid    = live(cur_reg);
        rsp_data_next.cursor_value    = out_val(cur_reg, cval_reg);
        rsp_data_next.list_nonempty   = live(head_reg);
        rsp_data_next.head_value      = out_val(head_reg, hval_reg);
        rsp_data_next.tail_value      = out_val(tail_reg, tval_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= NIL;
            tail_reg      <= NIL;
            cur_reg       <= NIL;
            fhead_reg     <= NIL;
            fresh_reg     <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            cur_reg   <= cur_next;
            fhead_reg <= fhead_next;
            fresh_reg <= fresh_next;
            count_reg <= count_next;
            if (state_reg == ST_COMMIT2 && rsp_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= req.payload.kind;
            value_reg <= DATA_BITS'(req.payload.value);
        end
        if (state_reg == ST_COMMIT2 && rsp_free)
        begin
            rsp_data_reg <= rsp_data_next;
        end
        node_reg <= node_next;
        hval_reg <= hval_next;
        tval_reg <= tval_next;
        cval_reg <= cval_next;
        nx1_reg  <= nx1_next;
        nx2_reg  <= nx2_next;
        pv1_reg  <= pv1_next;
        pv2_reg  <= pv2_next;
        dt_reg   <= dt_next;
        ld_reg   <= ld_next;
        full_reg <= full_next;
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_data_reg;

endmodule

>>> rtl/dllc_checker.sv
`timescale 1ns / 1ps

module dllc_checker
    import dllc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input dllc_rsp_t rsp_data
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_data))
        else $error("response changed while stalled");

    a_empty_list: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.list_nonempty |->
            rsp_data.list_length == 7'd0 && !rsp_data.cursor_valid &&
            rsp_data.head_value == 32'sd0 && rsp_data.tail_value == 32'sd0)
        else $error("empty list reports elements");

    a_cursor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.cursor_valid |-> rsp_data.cursor_value == 32'sd0)
        else $error("inactive cursor reports a value");

    a_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.pool_full_error |-> rsp_data.list_nonempty)
        else $error("pool full reported on an empty list");

endmodule

bind doubly_linked_list_cursor_engine_unit dllc_checker u_dllc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.payload)
);

>>> tb/doubly_linked_list_cursor_engine_unit_tb.sv
`timescale 1ns / 1ps

module doubly_linked_list_cursor_engine_unit_tb;
    import dllc_pkg::*;

    localparam int POOL        = POOL_ENTRIES_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 50;

    typedef logic [6:0] idx_t;
    localparam idx_t NIL_IDX = idx_t'(POOL);

    logic clk;
    logic rst_n;
    bit   quiet;
    int   error_count;
    int   cycle_count;

    dllc_req_if req_ch ();
    dllc_rsp_if rsp_ch ();

    doubly_linked_list_cursor_engine_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    logic signed [31:0] node_val [POOL];
    idx_t               link_fwd [POOL];
    idx_t               link_back[POOL];
    idx_t               first_idx;
    idx_t               last_idx;
    idx_t               cur_idx;
    idx_t               free_idx;
    logic [6:0]         used_count;

    dllc_rsp_t list_expect[$];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic bit is_node(idx_t i);
        return i < POOL;
    endfunction

    function automatic void list_clear();
        for (int i = 0; i < POOL; i++)
        begin
            node_val[i]  = '0;
            link_back[i] = '0;
            link_fwd[i]  = idx_t'(i + 1);
        end
        first_idx  = NIL_IDX;
        last_idx   = NIL_IDX;
        cur_idx    = NIL_IDX;
        free_idx   = '0;
        used_count = '0;
    endfunction

    function automatic idx_t grab_node(logic signed [31:0] d);
        idx_t n;
        n = free_idx;
        if (!is_node(n))
            return NIL_IDX;
        free_idx    = link_fwd[n];
        node_val[n] = d;
        used_count++;
        return n;
    endfunction

    function automatic void release_node(idx_t n);
        if (!is_node(n))
            return;
        link_fwd[n] = free_idx;
        free_idx    = n;
        if (used_count > 0)
            used_count--;
    endfunction

    function automatic logic signed [31:0] value_at(idx_t i);
        return is_node(i) ? node_val[i] : '0;
    endfunction

    function automatic dllc_rsp_t list_apply(dllc_req_t r);
        idx_t      c;
        idx_t      n;
        idx_t      x;
        logic      full;
        dllc_rsp_t res;
        c    = cur_idx;
        full = 1'b0;
        case (r.kind)
            K_INS_FIRST:
            begin
                n = grab_node(r.value);
                if (!is_node(n))
                    full = 1'b1;
                else
                begin
                    link_back[n] = NIL_IDX;
                    link_fwd[n]  = first_idx;
                    if (is_node(first_idx))
                        link_back[first_idx] = n;
                    else
                        last_idx = n;
                    first_idx = n;
                end
            end
            K_INS_LAST:
            begin
                n = grab_node(r.value);
                if (!is_node(n))
                    full = 1'b1;
                else
                begin
                    link_fwd[n]  = NIL_IDX;
                    link_back[n] = last_idx;
                    if (is_node(last_idx))
                        link_fwd[last_idx] = n;
                    else
                        first_idx = n;
                    last_idx = n;
                end
            end
            K_INS_BEFORE:
            begin
                if (is_node(c))
                begin
                    n = grab_node(r.value);
                    if (!is_node(n))
                        full = 1'b1;
                    else
                    begin
                        x            = link_back[c];
                        link_back[n] = x;
                        link_fwd[n]  = c;
                        if (is_node(x))
                            link_fwd[x] = n;
                        else
                            first_idx = n;
                        link_back[c] = n;
                    end
                end
            end
            K_INS_AFTER:
            begin
                if (is_node(c))
                begin
                    n = grab_node(r.value);
                    if (!is_node(n))
                        full = 1'b1;
                    else
                    begin
                        x            = link_fwd[c];
                        link_fwd[n]  = x;
                        link_back[n] = c;
                        if (is_node(x))
                            link_back[x] = n;
                        else
                            last_idx = n;
                        link_fwd[c] = n;
                    end
                end
            end
            K_DEL_FIRST:
            begin
                n = first_idx;
                if (is_node(n))
                begin
                    first_idx = link_fwd[n];
                    if (is_node(first_idx))
                        link_back[first_idx] = NIL_IDX;
                    else
                        last_idx = NIL_IDX;
                    if (c == n)
                        cur_idx = NIL_IDX;
                    release_node(n);
                end
            end
            K_DEL_LAST:
            begin
                n = last_idx;
                if (is_node(n))
                begin
                    last_idx = link_back[n];
                    if (is_node(last_idx))
                        link_fwd[last_idx] = NIL_IDX;
                    else
                        first_idx = NIL_IDX;
                    if (c == n)
                        cur_idx = NIL_IDX;
                    release_node(n);
                end
            end
            K_DEL_BEFORE:
            begin
                if (is_node(c) && is_node(link_back[c]))
                begin
                    n            = link_back[c];
                    x            = link_back[n];
                    link_back[c] = x;
                    if (is_node(x))
                        link_fwd[x] = c;
                    else
                        first_idx = c;
                    release_node(n);
                end
            end
            K_DEL_AFTER:
            begin
                if (is_node(c) && is_node(link_fwd[c]))
                begin
                    n           = link_fwd[c];
                    x           = link_fwd[n];
                    link_fwd[c] = x;
                    if (is_node(x))
                        link_back[x] = c;
                    else
                        last_idx = c;
                    release_node(n);
                end
            end
            K_SET:
            begin
                if (is_node(c))
                    node_val[c] = r.value;
            end
            K_FIRST:
                cur_idx = is_node(first_idx) ? first_idx : NIL_IDX;
            K_LAST:
                cur_idx = is_node(last_idx) ? last_idx : NIL_IDX;
            K_NEXT:
            begin
                if (is_node(c))
                    cur_idx = is_node(link_fwd[c]) ? link_fwd[c] : NIL_IDX;
            end
            K_PREV:
            begin
                if (is_node(c))
                    cur_idx = is_node(link_back[c]) ? link_back[c] : NIL_IDX;
            end
            K_DISPOSE:
            begin
                if (is_node(first_idx) && is_node(last_idx))
                begin
                    link_fwd[last_idx] = free_idx;
                    free_idx           = first_idx;
                end
                first_idx  = NIL_IDX;
                last_idx   = NIL_IDX;
                cur_idx    = NIL_IDX;
                used_count = '0;
            end
            default:
            begin
            end
        endcase
        res.pool_full_error = full;
        res.list_length     = used_count;
        res.cursor_valid    = is_node(cur_idx);
        res.cursor_value    = value_at(cur_idx);
        res.list_nonempty   = is_node(first_idx);
        res.head_value      = value_at(first_idx);
        res.tail_value      = value_at(last_idx);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < PRINT_LIMIT)
            $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    task automatic check_result(input dllc_rsp_t got);
        dllc_rsp_t want;
        if (list_expect.size() == 0)
        begin
            report_mismatch("result with no request", 32'(got.list_length), '0);
            return;
        end
        want = list_expect.pop_front();
        if (got.pool_full_error !== want.pool_full_error)
            report_mismatch("pool_full_error", 32'(got.pool_full_error),
                            32'(want.pool_full_error));
        if (got.list_length !== want.list_length)
            report_mismatch("list_length", 32'(got.list_length), 32'(want.list_length));
        if (got.cursor_valid !== want.cursor_valid)
            report_mismatch("cursor_valid", 32'(got.cursor_valid), 32'(want.cursor_valid));
        if (got.cursor_value !== want.cursor_value)
            report_mismatch("cursor_value", got.cursor_value, want.cursor_value);
        if (got.list_nonempty !== want.list_nonempty)
            report_mismatch("list_nonempty", 32'(got.list_nonempty),
                            32'(want.list_nonempty));
        if (got.head_value !== want.head_value)
            report_mismatch("head_value", got.head_value, want.head_value);
        if (got.tail_value !== want.tail_value)
            report_mismatch("tail_value", got.tail_value, want.tail_value);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            check_result(rsp_ch.payload);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input logic [3:0] kind, input logic [31:0] value);
        dllc_req_t item;
        item.kind  = kind;
        item.value = value;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= item;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        list_expect.push_back(list_apply(item));
        @(negedge clk);
    endtask

    // Hold off until every pending request has its result.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (list_expect.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [3:0] pick_kind(int grow_bias);
        int r;
        r = $urandom_range(0, 99);
        if (r < grow_bias)
            return 4'($urandom_range(K_INS_FIRST, K_INS_AFTER));
        else if (r < grow_bias + 20)
            return 4'($urandom_range(K_DEL_FIRST, K_DEL_AFTER));
        else if (r < 96)
            return 4'($urandom_range(K_SET, K_PREV));
        else if (r < 98)
            return 4'($urandom_range(0, 15));
        else
            return K_DISPOSE;
    endfunction

    task automatic test_empty_list();
        send_request(K_QUERY, pick_value());
        send_request(4'hF, pick_value());
        send_request(K_DEL_FIRST, pick_value());
        send_request(K_DEL_LAST, pick_value());
        send_request(K_DEL_BEFORE, pick_value());
        send_request(K_NEXT, pick_value());
        send_request(K_SET, 32'h1234_5678);
        send_request(K_FIRST, pick_value());
        send_request(K_INS_AFTER, 32'h0BAD_F00D);
        send_request(K_DISPOSE, pick_value());
    endtask

    task automatic test_cursor_edges();
        send_request(K_INS_LAST, 32'h7FFF_FFFF);
        send_request(K_INS_FIRST, 32'h8000_0000);
        send_request(K_FIRST, '0);
        send_request(K_PREV, '0);
        send_request(K_LAST, '0);
        send_request(K_NEXT, '0);
        send_request(K_LAST, '0);
        send_request(K_INS_BEFORE, 32'h0000_0000);
        send_request(K_INS_AFTER, 32'hFFFF_FFFF);
        send_request(K_DEL_BEFORE, '0);
        send_request(K_DEL_AFTER, '0);
        send_request(K_DEL_AFTER, '0);
        send_request(K_FIRST, '0);
        send_request(K_DEL_BEFORE, '0);
        send_request(K_SET, 32'h5555_AAAA);
        send_request(K_DEL_FIRST, '0);
        send_request(K_LAST, '0);
        send_request(K_DEL_LAST, '0);
    endtask

    task automatic test_pool_exhaust();
        drain_results();
        send_request(K_DISPOSE, '0);
        send_request(K_INS_LAST, pick_value());
        send_request(K_FIRST, '0);
        for (int i = 1; i < POOL; i++)
            send_request(4'($urandom_range(K_INS_FIRST, K_INS_AFTER)), pick_value());
        send_request(K_INS_FIRST, pick_value());
        send_request(K_INS_LAST, pick_value());
        send_request(K_INS_BEFORE, pick_value());
        send_request(K_INS_AFTER, pick_value());
        send_request(K_LAST, '0);
        send_request(K_NEXT, '0);
        send_request(K_INS_BEFORE, pick_value());
        send_request(K_DEL_LAST, '0);
        send_request(K_FIRST, '0);
        send_request(K_INS_AFTER, pick_value());
        send_request(K_INS_BEFORE, pick_value());
        repeat (20)
            send_request(pick_kind(20), pick_value());
        send_request(K_DISPOSE, '0);
        repeat (12)
            send_request(pick_kind(80), pick_value());
        drain_results();
        send_request(K_DISPOSE, '0);
    endtask

    task automatic test_random_walk();
        int bias[5] = '{70, 15, 45, 75, 10};
        foreach (bias[s])
        begin
            repeat (130)
                send_request(pick_kind(bias[s]), pick_value());
            if (s == 2)
                drain_results();
        end
    endtask

    task automatic test_steady_stream();
        quiet = 1'b1;
        repeat (60)
            send_request(pick_kind(45), pick_value());
    endtask

    initial
    begin
        int waited;
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        quiet          = 1'b0;
        error_count    = 0;
        cycle_count    = 0;
        list_clear();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_cursor_edges();
        test_pool_exhaust();
        test_random_walk();
        test_steady_stream();

        req_ch.valid <= 1'b0;
        waited = 0;
        while (list_expect.size() != 0 && waited < 5000)
        begin
            @(negedge clk);
            waited++;
        end
        if (list_expect.size() != 0)
            report_mismatch("results never came", 32'(list_expect.size()), '0);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
